[hw/rtl/lfg_pkg.sv]
// Shared types and constants of the load threshold frequency governor.
`default_nettype none
package lfg_pkg;

	localparam int unsigned CNT_W    = 64;
	localparam int unsigned FREQ_W   = 24;
	localparam int unsigned LOAD_W   = 7;
	localparam int unsigned HOLD_W   = 8;
	localparam int unsigned PADDR_W  = 4;
	localparam int unsigned PDATA_W  = 32;
	// 100 * busy needs seven more bits than the counter delta
	localparam int unsigned PROD_W   = CNT_W + LOAD_W;
	// divisor aligned to the top quotient bit
	localparam int unsigned DIVS_W   = CNT_W + LOAD_W - 1;
	localparam int unsigned DIV_STEPS = LOAD_W;
	localparam int unsigned STEP_W   = 3;

	localparam logic [LOAD_W-1:0] THRESHOLD_RST = 7'd5;
	localparam logic [HOLD_W-1:0] HOLD_RST      = 8'd2;
	localparam logic [FREQ_W-1:0] MAX_FREQ_RST  = 24'd3000000;
	localparam logic [FREQ_W-1:0] MIN_FREQ_RST  = 24'd300000;

	typedef enum logic [1:0] {
		REG_LOAD_THRESHOLD = 2'd0,
		REG_HOLD_TICKS     = 2'd1,
		REG_MAX_FREQ       = 2'd2,
		REG_MIN_FREQ       = 2'd3
	} lfg_reg_t;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_DIFF   = 5'b00010,
		ST_SCALE  = 5'b00100,
		ST_DIV    = 5'b01000,
		ST_DECIDE = 5'b10000
	} lfg_state_t;

	typedef struct packed {
		logic capture;
		logic diff;
		logic scale;
		logic step;
		logic finish;
	} lfg_cmd_t;

	typedef struct packed {
		logic out_free;
	} lfg_sts_t;

	typedef struct packed {
		logic [LOAD_W-1:0] load_threshold;
		logic [HOLD_W-1:0] hold_ticks;
		logic [FREQ_W-1:0] max_freq;
		logic [FREQ_W-1:0] min_freq;
	} lfg_cfg_t;

endpackage
`default_nettype wire

[hw/rtl/lfg_if.sv]
// Sample and result channel interfaces of the frequency governor.
`default_nettype none
interface lfg_sample_if;
	import lfg_pkg::*;
	logic              valid;
	logic              ready;
	logic [CNT_W-1:0]  idle_time;
	logic [CNT_W-1:0]  wall_time;
	logic [FREQ_W-1:0] current_freq;

	modport source (output valid, idle_time, wall_time, current_freq, input ready);
	modport sink   (input valid, idle_time, wall_time, current_freq, output ready);
endinterface

interface lfg_result_if;
	import lfg_pkg::*;
	logic              valid;
	logic              ready;
	logic              change_request;
	logic [FREQ_W-1:0] target_freq;
	logic [LOAD_W-1:0] load_percent;

	modport source (output valid, change_request, target_freq, load_percent, input ready);
	modport sink   (input valid, change_request, target_freq, load_percent, output ready);
endinterface
`default_nettype wire

[hw/rtl/lfg_ctrl.sv]
// Sequencing state machine of the frequency governor.
`default_nettype none
module lfg_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          sample_valid,
	output logic               sample_ready,
	input  lfg_pkg::lfg_sts_t  sts,
	output lfg_pkg::lfg_cmd_t  cmd
);
	import lfg_pkg::*;

	lfg_state_t        state_q, state_d;
	logic [STEP_W-1:0] step_q, step_d;

	always_comb begin
		state_d      = state_q;
		step_d       = step_q;
		cmd          = '0;
		sample_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				sample_ready = 1'b1;
				if (sample_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_DIFF;
				end
			end
			ST_DIFF: begin
				cmd.diff = 1'b1;
				state_d  = ST_SCALE;
			end
			ST_SCALE: begin
				cmd.scale = 1'b1;
				step_d    = STEP_W'(DIV_STEPS - 1);
				state_d   = ST_DIV;
			end
			ST_DIV: begin
				cmd.step = 1'b1;
				if (step_q == '0) begin
					state_d = ST_DECIDE;
				end else begin
					step_d = step_q - 1'b1;
				end
			end
			ST_DECIDE: begin
				// hold until the result register can take the new result
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end

endmodule
`default_nettype wire

[hw/rtl/lfg_dp.sv]
// Datapath of the frequency governor: deltas, scaled divide, decision, result register.
`default_nettype none
module lfg_dp (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  lfg_pkg::lfg_cmd_t                cmd,
	output lfg_pkg::lfg_sts_t                sts,
	input  lfg_pkg::lfg_cfg_t                cfg,
	input  wire logic [lfg_pkg::CNT_W-1:0]   idle_time,
	input  wire logic [lfg_pkg::CNT_W-1:0]   wall_time,
	input  wire logic [lfg_pkg::FREQ_W-1:0]  current_freq,
	output logic                             res_valid,
	input  wire logic                        res_ready,
	output logic                             change_request,
	output logic [lfg_pkg::FREQ_W-1:0]       target_freq,
	output logic [lfg_pkg::LOAD_W-1:0]       load_percent
);
	import lfg_pkg::*;

	// history kept between samples
	logic [CNT_W-1:0]  last_wall_q, last_idle_q;
	logic [HOLD_W-1:0] hold_left_q;

	// per-sample working registers
	logic              first_q, zero_q;
	logic [CNT_W-1:0]  dwall_q, didle_q, busy_q;
	logic [FREQ_W-1:0] cur_q;
	logic [PROD_W-1:0] rem_q;
	logic [DIVS_W-1:0] divisor_q;
	logic [LOAD_W-1:0] quo_q;

	// result register
	logic              out_valid_q, change_q;
	logic [FREQ_W-1:0] target_q;
	logic [LOAD_W-1:0] load_q;

	logic [PROD_W-1:0] busy_ext, prod;
	logic [PROD_W-1:0] divisor_ext;
	logic              fits;
	logic [LOAD_W-1:0] load_val;
	logic [FREQ_W-1:0] target_val;
	logic [HOLD_W-1:0] hold_next;

	// 100 = 64 + 32 + 4
	assign busy_ext    = PROD_W'(busy_q);
	assign prod        = (busy_ext << 6) + (busy_ext << 5) + (busy_ext << 2);
	assign divisor_ext = PROD_W'(divisor_q);
	assign fits        = (rem_q >= divisor_ext);

	always_comb begin
		load_val   = zero_q ? '0 : quo_q;
		hold_next  = hold_left_q;
		target_val = cfg.min_freq;
		if (load_val > cfg.load_threshold) begin
			target_val = cfg.max_freq;
			hold_next  = cfg.hold_ticks;
		end else if (hold_left_q != '0) begin
			target_val = cfg.max_freq;
			hold_next  = hold_left_q - 1'b1;
		end
	end

	assign sts.out_free = !out_valid_q || res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_wall_q <= '0;
			last_idle_q <= '0;
			hold_left_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.capture) begin
				last_wall_q <= wall_time;
				last_idle_q <= idle_time;
			end
			if (cmd.finish && !first_q) begin
				hold_left_q <= hold_next;
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			first_q <= (last_wall_q == '0);
			dwall_q <= wall_time - last_wall_q;
			didle_q <= idle_time - last_idle_q;
			cur_q   <= current_freq;
		end
		if (cmd.diff) begin
			zero_q <= (dwall_q == '0) || (didle_q > dwall_q);
			busy_q <= dwall_q - didle_q;
		end
		if (cmd.scale) begin
			rem_q     <= prod;
			divisor_q <= {dwall_q, (LOAD_W-1)'(0)};
			quo_q     <= '0;
		end
		if (cmd.step) begin
			if (fits) begin
				rem_q <= rem_q - divisor_ext;
			end
			quo_q     <= {quo_q[LOAD_W-2:0], fits};
			divisor_q <= divisor_q >> 1;
		end
		if (cmd.finish) begin
			if (first_q) begin
				change_q <= 1'b0;
				target_q <= '0;
				load_q   <= '0;
			end else begin
				change_q <= (target_val != cur_q);
				target_q <= (target_val != cur_q) ? target_val : '0;
				load_q   <= load_val;
			end
		end
	end

	assign res_valid      = out_valid_q;
	assign change_request = change_q;
	assign target_freq    = target_q;
	assign load_percent   = load_q;

endmodule
`default_nettype wire

[hw/rtl/load_threshold_freq_governor.sv]
// Top level of the load threshold frequency governor: register file and core.
`default_nettype none
// Threshold frequency governor with hold. Each sample transaction carries the
// cumulative idle and wall counters of a CPU and its present frequency; each
// one yields exactly one result transaction. The first sample after reset (or
// any sample that finds the stored wall counter at zero) only records the
// counters and returns an all-zero result. Later samples compute
// load = floor(100 * (dwall - didle) / dwall) over the full 71-bit product,
// with load forced to zero when no time has passed or the idle delta exceeds
// the wall delta; counters that run backwards wrap modulo 2^64. A load above
// load_threshold selects max_freq and reloads the hold counter from
// hold_ticks; otherwise max_freq is kept while the hold counter counts down,
// then min_freq is chosen. change_request is set, and target_freq carries the
// choice, only when it differs from current_freq. One sample is in work at
// a time: after acceptance it passes through the deltas, the scaling, the
// restoring divide that produces the load one bit per cycle, and the
// decision, which writes its result to the output register; the next sample
// is accepted in the cycle after its result is written, while that result
// may still wait in the output register, so no new sample is taken before
// the last one's result is written, and a waiting result holds the decision
// back. Registers sit at byte addresses 0 (load_threshold), 4 (hold_ticks),
// 8 (max_freq) and 12 (min_freq); writes decode on paddr[3:2] and must be
// made while idle.
module load_threshold_freq_governor (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	lfg_sample_if.sink                        sample,
	lfg_result_if.source                      result,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [lfg_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [lfg_pkg::PDATA_W-1:0]  pwdata,
	output logic [lfg_pkg::PDATA_W-1:0]       prdata,
	output logic                              pready
);
	import lfg_pkg::*;

	lfg_cfg_t cfg_q;
	lfg_cmd_t cmd;
	lfg_sts_t sts;
	lfg_reg_t reg_sel;
	logic     wr_en;

	assign pready  = 1'b1;
	assign reg_sel = lfg_reg_t'(paddr[3:2]);
	assign wr_en   = psel && penable && pwrite;

	// configuration registers; write on the APB access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.load_threshold <= THRESHOLD_RST;
			cfg_q.hold_ticks     <= HOLD_RST;
			cfg_q.max_freq       <= MAX_FREQ_RST;
			cfg_q.min_freq       <= MIN_FREQ_RST;
		end else if (wr_en) begin
			unique case (reg_sel)
				REG_LOAD_THRESHOLD: cfg_q.load_threshold <= pwdata[LOAD_W-1:0];
				REG_HOLD_TICKS:     cfg_q.hold_ticks     <= pwdata[HOLD_W-1:0];
				REG_MAX_FREQ:       cfg_q.max_freq       <= pwdata[FREQ_W-1:0];
				REG_MIN_FREQ:       cfg_q.min_freq       <= pwdata[FREQ_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// read back, zero-extended to the bus width
	always_comb begin
		unique case (reg_sel)
			REG_LOAD_THRESHOLD: prdata = PDATA_W'(cfg_q.load_threshold);
			REG_HOLD_TICKS:     prdata = PDATA_W'(cfg_q.hold_ticks);
			REG_MAX_FREQ:       prdata = PDATA_W'(cfg_q.max_freq);
			REG_MIN_FREQ:       prdata = PDATA_W'(cfg_q.min_freq);
			default:            prdata = '0;
		endcase
	end

	// sequencer: accept one sample, then walk diff, scale, divide, decide
	lfg_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample.valid),
		.sample_ready (sample.ready),
		.sts          (sts),
		.cmd          (cmd)
	);

	// datapath holds the counter history, hold counter and result register
	lfg_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.cfg            (cfg_q),
		.idle_time      (sample.idle_time),
		.wall_time      (sample.wall_time),
		.current_freq   (sample.current_freq),
		.res_valid      (result.valid),
		.res_ready      (result.ready),
		.change_request (result.change_request),
		.target_freq    (result.target_freq),
		.load_percent   (result.load_percent)
	);

endmodule
`default_nettype wire

[tb/sv/load_threshold_freq_governor_test.sv]
// Self-checking testbench for the load threshold frequency governor.
module load_threshold_freq_governor_test;
	import lfg_pkg::*;

	// One sample transaction as the driver presents it.
	typedef struct packed {
		logic [CNT_W-1:0]  idle_time;
		logic [CNT_W-1:0]  wall_time;
		logic [FREQ_W-1:0] current_freq;
	} cpu_sample_t;

	// One governor decision as the result channel carries it.
	typedef struct packed {
		logic              change_request;
		logic [FREQ_W-1:0] target_freq;
		logic [LOAD_W-1:0] load_percent;
	} gov_verdict_t;

	logic                 clk;
	logic                 arst_n;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [PADDR_W-1:0]   paddr;
	logic [PDATA_W-1:0]   pwdata;
	logic [PDATA_W-1:0]   prdata;
	logic                 pready;

	lfg_sample_if sample_ch ();
	lfg_result_if result_ch ();

	load_threshold_freq_governor i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.sample  (sample_ch),
		.result  (result_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Samples waiting to be driven, and decisions waiting to come out.
	cpu_sample_t  sample_q[$];
	gov_verdict_t verdict_q[$];
	cpu_sample_t  head;
	bit           sample_fire = 1'b0;

	// Governor state and register copy kept by the testbench.
	lfg_cfg_t         gov_cfg;
	logic [CNT_W-1:0] last_wall;
	logic [CNT_W-1:0] last_idle;
	logic [HOLD_W-1:0] hold_left;

	// Running counters from which new samples are built.
	logic [CNT_W-1:0] gen_idle;
	logic [CNT_W-1:0] gen_wall;

	// Chance, in percent per cycle, that each side holds off.
	int unsigned gap_pct = 30;
	int unsigned stall_pct = 30;

	int unsigned n_errors = 0;
	int unsigned n_samples = 0;
	int unsigned n_changes = 0;
	int unsigned n_restarts = 0;
	int unsigned n_settings = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Give up long after the slowest correct run would have finished.
	initial begin
		#3000000;
		$display("timeout: %0d decisions still outstanding", verdict_q.size());
		$display("CHECK FAILED");
		$finish;
	end

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		n_errors++;
		$display("mismatch at %0t: %s is 0x%0h, should be 0x%0h", $time, what, got, want);
	endtask

	// Work out the decision for one accepted sample and advance the state.
	function automatic gov_verdict_t govern_sample(logic [CNT_W-1:0] idle,
			logic [CNT_W-1:0] wall, logic [FREQ_W-1:0] cur);
		gov_verdict_t      v;
		logic [CNT_W-1:0]  dwall;
		logic [CNT_W-1:0]  didle;
		logic [PROD_W-1:0] scaled;
		logic [PROD_W-1:0] quo;
		logic [LOAD_W-1:0] load;
		logic [FREQ_W-1:0] pick;
		v = '0;
		// a stored wall count of zero means there is nothing to compare with yet
		if (last_wall == '0) begin
			last_wall = wall;
			last_idle = idle;
			n_restarts++;
			return v;
		end
		dwall = wall - last_wall;
		didle = idle - last_idle;
		last_wall = wall;
		last_idle = idle;
		if (dwall == '0 || didle > dwall) begin
			load = '0;
		end else begin
			// full-width product, so even all-ones deltas give an exact floor
			scaled = PROD_W'(dwall - didle) * PROD_W'(100);
			quo = scaled / PROD_W'(dwall);
			load = quo[LOAD_W-1:0];
		end
		if (load > gov_cfg.load_threshold) begin
			pick = gov_cfg.max_freq;
			hold_left = gov_cfg.hold_ticks;
		end else if (hold_left != '0) begin
			hold_left = hold_left - 1'b1;
			pick = gov_cfg.max_freq;
		end else begin
			pick = gov_cfg.min_freq;
		end
		if (pick != cur) begin
			v.change_request = 1'b1;
			v.target_freq = pick;
		end
		v.load_percent = load;
		return v;
	endfunction

	// Write a register with an APB setup and an access phase, then read it back.
	task automatic write_reg(lfg_reg_t idx, logic [PDATA_W-1:0] value);
		logic [PDATA_W-1:0] kept;
		logic [PDATA_W-1:0] readback;
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 2'b00};
		pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		pwrite = 1'b0;
		penable = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		readback = prdata;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		case (idx)
			REG_LOAD_THRESHOLD: begin
				gov_cfg.load_threshold = value[LOAD_W-1:0];
				kept = PDATA_W'(value[LOAD_W-1:0]);
			end
			REG_HOLD_TICKS: begin
				gov_cfg.hold_ticks = value[HOLD_W-1:0];
				kept = PDATA_W'(value[HOLD_W-1:0]);
			end
			REG_MAX_FREQ: begin
				gov_cfg.max_freq = value[FREQ_W-1:0];
				kept = PDATA_W'(value[FREQ_W-1:0]);
			end
			default: begin
				gov_cfg.min_freq = value[FREQ_W-1:0];
				kept = PDATA_W'(value[FREQ_W-1:0]);
			end
		endcase
		if (readback !== kept)
			report_mismatch("register readback", readback, kept);
	endtask

	// Load all four registers; junk above each field must be dropped.
	task automatic apply_setting(logic [LOAD_W-1:0] thr, logic [HOLD_W-1:0] hold,
			logic [FREQ_W-1:0] fmax, logic [FREQ_W-1:0] fmin);
		write_reg(REG_LOAD_THRESHOLD, ($urandom << LOAD_W) | PDATA_W'(thr));
		write_reg(REG_HOLD_TICKS, ($urandom << HOLD_W) | PDATA_W'(hold));
		write_reg(REG_MAX_FREQ, ($urandom << FREQ_W) | PDATA_W'(fmax));
		write_reg(REG_MIN_FREQ, ($urandom << FREQ_W) | PDATA_W'(fmin));
		n_settings++;
	endtask

	task automatic queue_sample(logic [CNT_W-1:0] idle, logic [CNT_W-1:0] wall,
			logic [FREQ_W-1:0] cur);
		gen_idle = idle;
		gen_wall = wall;
		sample_q.push_back('{idle_time: idle, wall_time: wall, current_freq: cur});
	endtask

	// Present frequency: mostly one of the two limits, so both outcomes occur.
	function automatic logic [FREQ_W-1:0] pick_freq();
		case ($urandom_range(4))
			0, 1: return gov_cfg.max_freq;
			2, 3: return gov_cfg.min_freq;
			default: return FREQ_W'($urandom);
		endcase
	endfunction

	// Mostly counters that advance sensibly, with the rest noise and restarts.
	task automatic queue_random_sample();
		int unsigned       dice;
		int unsigned       pct;
		int unsigned       top;
		logic [CNT_W-1:0]  dwall;
		logic [CNT_W-1:0]  busy;
		logic [CNT_W-1:0]  extra;
		logic [PROD_W-1:0] wide;
		dice = $urandom_range(99);
		if (dice < 75) begin
			case ($urandom_range(3))
				0: dwall = $urandom_range(1000, 1);
				1: dwall = $urandom;
				2: dwall = {$urandom, $urandom} >> $urandom_range(63);
				default: dwall = 100;
			endcase
			// half the loads at or under the threshold, so the hold runs down
			top = (gov_cfg.load_threshold > 100) ? 100 : gov_cfg.load_threshold;
			pct = $urandom_range(1) ? $urandom_range(top) : $urandom_range(100);
			// aim exactly at the threshold and one above it
			if (dwall == 100 && $urandom_range(1))
				pct = (top + 1 > 100) ? 100 : top + $urandom_range(1);
			wide = PROD_W'(dwall) * PROD_W'(pct);
			busy = CNT_W'(wide / PROD_W'(100));
			queue_sample(gen_idle + (dwall - busy), gen_wall + dwall, pick_freq());
		end else if (dice < 80) begin
			// no time elapsed
			queue_sample(gen_idle + $urandom_range(3), gen_wall, pick_freq());
		end else if (dice < 85) begin
			// idle advancing faster than wall time
			extra = $urandom_range(5000, 1);
			dwall = $urandom_range(5000, 1);
			queue_sample(gen_idle + dwall + extra, gen_wall + dwall, pick_freq());
		end else if (dice < 93) begin
			// arbitrary counters, often running backwards
			queue_sample({$urandom, $urandom}, {$urandom, $urandom}, pick_freq());
		end else if (dice < 97) begin
			// wall count of zero forces a fresh start
			queue_sample({$urandom, $urandom}, '0, pick_freq());
		end else begin
			queue_sample($urandom_range(1) ? '1 : '0,
				$urandom_range(1) ? '1 : {1'b1, {(CNT_W-1){1'b0}}}, pick_freq());
		end
	endtask

	// Hold until every sample is out and every decision is back, then settle.
	task automatic drain();
		while (sample_q.size() != 0 || sample_ch.valid || verdict_q.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	// Driver: advance to the next sample once the current one has gone.
	always @(negedge clk) begin
		if (!sample_ch.valid || sample_fire) begin
			if (arst_n && sample_q.size() != 0 && $urandom_range(99) >= gap_pct) begin
				head = sample_q.pop_front();
				sample_ch.valid <= 1'b1;
				sample_ch.idle_time <= head.idle_time;
				sample_ch.wall_time <= head.wall_time;
				sample_ch.current_freq <= head.current_freq;
			end else begin
				sample_ch.valid <= 1'b0;
			end
		end
		result_ch.ready <= ($urandom_range(99) >= stall_pct);
	end

	// Monitor: predict on each accepted sample, check each accepted result.
	always @(posedge clk) begin
		gov_verdict_t want;
		if (!arst_n) begin
			sample_fire <= 1'b0;
		end else begin
			sample_fire <= sample_ch.valid && sample_ch.ready;
			if (sample_ch.valid && sample_ch.ready) begin
				n_samples++;
				verdict_q.push_back(govern_sample(sample_ch.idle_time,
					sample_ch.wall_time, sample_ch.current_freq));
			end
			if (result_ch.valid && result_ch.ready) begin
				if (verdict_q.size() == 0) begin
					report_mismatch("unexpected result, load_percent",
						result_ch.load_percent, 0);
				end else begin
					want = verdict_q.pop_front();
					if (want.change_request)
						n_changes++;
					if (result_ch.change_request !== want.change_request)
						report_mismatch("change_request", result_ch.change_request,
							want.change_request);
					if (result_ch.target_freq !== want.target_freq)
						report_mismatch("target_freq", result_ch.target_freq,
							want.target_freq);
					if (result_ch.load_percent !== want.load_percent)
						report_mismatch("load_percent", result_ch.load_percent,
							want.load_percent);
				end
			end
		end
	end

	initial begin
		int unsigned phase;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		sample_ch.valid = 1'b0;
		sample_ch.idle_time = '0;
		sample_ch.wall_time = '0;
		sample_ch.current_freq = '0;
		result_ch.ready = 1'b0;
		gov_cfg = '{load_threshold: THRESHOLD_RST, hold_ticks: HOLD_RST,
			max_freq: MAX_FREQ_RST, min_freq: MIN_FREQ_RST};
		last_wall = '0;
		last_idle = '0;
		hold_left = '0;
		gen_idle = '0;
		gen_wall = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed run on the reset settings: threshold 5, hold 2.
		// A zero wall count leaves the block waiting for a first sample.
		queue_sample(0, 0, 0);
		queue_sample(5, 1000, '1);
		// full load selects the maximum, already running there
		queue_sample(5, 1100, MAX_FREQ_RST);
		// load equal to the threshold: hold counts down, maximum kept
		queue_sample(100, 1200, MIN_FREQ_RST);
		// one above the threshold reloads the hold
		queue_sample(194, 1300, 0);
		// idle from here: two held samples, then the minimum
		queue_sample(294, 1400, MAX_FREQ_RST);
		queue_sample(394, 1500, MIN_FREQ_RST);
		queue_sample(494, 1600, MIN_FREQ_RST);
		// no elapsed time
		queue_sample(494, 1600, 0);
		// idle delta beyond wall delta
		queue_sample(1000, 1700, '1);
		// wall count running backwards wraps round
		queue_sample(1000, 500, 0);
		queue_sample(7, 1, 0);
		// all-ones wall delta with no idle: exactly full load
		queue_sample(7, 0, MAX_FREQ_RST);
		queue_sample(0, '1, 0);
		// all-ones wall delta, one idle tick short of full
		queue_sample(1, {{(CNT_W-1){1'b1}}, 1'b0}, MAX_FREQ_RST);
		queue_sample('1, {1'b0, {(CNT_W-1){1'b1}}}, 24'h800000);
		drain();

		for (phase = 0; phase < 9; phase++) begin
			case (phase)
				0: apply_setting(0, 0, '1, 0);
				// minimum above maximum, longest hold
				1: apply_setting(100, 8'hFF, 0, '1);
				// threshold that no load can exceed
				2: apply_setting(7'h7F, 3, 1234567, 7654321);
				8: apply_setting(50, 1, MAX_FREQ_RST, MIN_FREQ_RST);
				default: apply_setting(LOAD_W'($urandom_range(100)),
					HOLD_W'($urandom_range(6)), FREQ_W'($urandom), FREQ_W'($urandom));
			endcase
			// one stretch with both sides flat out
			gap_pct = (phase == 1) ? 0 : 30;
			stall_pct = (phase == 1) ? 0 : 30;
			repeat (100) queue_random_sample();
			drain();
		end

		$display("covered %0d samples under %0d register settings plus reset values",
			n_samples, n_settings);
		$display("%0d frequency changes requested, %0d fresh starts, %0d mismatches",
			n_changes, n_restarts, n_errors);
		if (n_errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

[sim.f]
hw/rtl/lfg_pkg.sv
hw/rtl/lfg_if.sv
hw/rtl/lfg_ctrl.sv
hw/rtl/lfg_dp.sv
hw/rtl/load_threshold_freq_governor.sv
tb/sv/load_threshold_freq_governor_test.sv
